[design/lgmt_pkg.sv]
// shared types, constants and arithmetic helpers for the layout record table
package lgmt_pkg;

	localparam int ENTRIES = 8;
	localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int TOL_W   = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

	typedef enum logic [2:0] {
		FN_FIND_EXACT = 3'd0,
		FN_FIND_SIZE  = 3'd1,
		FN_ALLOC      = 3'd2,
		FN_RECENT     = 3'd3,
		FN_FLUSH      = 3'd4
	} func_t;

	typedef struct packed {
		logic [15:0]        surface;
		logic [15:0]        transform;
		logic signed [31:0] x_origin;
		logic signed [31:0] x_span;
		logic [16:0]        x_align;
		logic signed [31:0] y_origin;
		logic signed [31:0] y_span;
		logic [16:0]        y_align;
	} rec_t;

	typedef struct packed {
		rec_t              rec;
		logic [SLOT_W-1:0] slot;
	} entry_t;

	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_SHIFT = 2'd1,
		SEL_LOAD  = 2'd2
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t sel;
		logic      exact;
	} cell_ctl_t;

	function automatic logic near(input logic signed [32:0] a, input logic signed [32:0] b,
			input logic [TOL_W-1:0] tol);
		logic signed [33:0] d;
		logic [33:0]        m;
		d = 34'(a) - 34'(b);
		m = d[33] ? 34'(-d) : 34'(d);
		return m <= 34'(tol);
	endfunction

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		if (d[32] != d[31]) begin
			return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return d[31:0];
	endfunction

endpackage

[design/lgmt_cell.sv]
// one recency position: holds a record, compares it and passes it to its neighbor
module lgmt_cell import lgmt_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  rec_t             req,
	input  logic [TOL_W-1:0] tol,
	input  entry_t           load_word,
	input  entry_t           next_word,
	output entry_t           word,
	output logic             match
);

	entry_t word_q;
	logic   id_ok, size_ok, org_ok;

	always_comb begin
		id_ok   = (word_q.rec.surface == req.surface) &&
			((req.surface == 16'd0) || (word_q.rec.transform == req.transform));
		size_ok = near(33'(word_q.rec.x_span), 33'(req.x_span), tol) &&
			near(33'(word_q.rec.y_span), 33'(req.y_span), tol) &&
			near(33'($signed({1'b0, word_q.rec.x_align})),
				33'($signed({1'b0, req.x_align})), tol) &&
			near(33'($signed({1'b0, word_q.rec.y_align})),
				33'($signed({1'b0, req.y_align})), tol);
		org_ok  = near(33'(word_q.rec.x_origin), 33'(req.x_origin), tol) &&
			near(33'(word_q.rec.y_origin), 33'(req.y_origin), tol);
		match   = id_ok && size_ok && (!ctl.exact || org_ok);
	end

	always_ff @(posedge clk) begin
		unique case (ctl.sel)
			SEL_SHIFT: word_q <= next_word;
			SEL_LOAD:  word_q <= load_word;
			default:   word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

[design/lru_geometry_match_table_top.sv]
// top level of the layout record table with least-recently-used ordering
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tuser carry one request word; s_tuser holds the
//   operation code. m_tvalid/m_tready/m_tdata/m_tuser return exactly one result
//   word per request, in order. cfg_valid/cfg_data write the match tolerance;
//   cfg_ready is always high and writes belong to idle periods.
//   Records sit in a row of cells ordered from least to most recently used. A
//   request is registered on acceptance, then in the following cycle every cell
//   compares in parallel, the first hit from the old end wins, and the cells from
//   the hit up shift toward the old end by one cell while the hit or new record
//   drops into the newest position; a fill of a free cell shifts nothing.
//   The request register passes its word to the result register once the output
//   is free; a new request is taken only after that, since the request register
//   holds one word while the cell row compares and shifts.
//   Reset empties the table and sets the tolerance to 7; record contents are
//   not cleared. When the receiver stalls the result waits in the output
//   register, the next request is still taken and then held until the output
//   frees.
module lru_geometry_match_table_top import lgmt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// surface_id, transform_id, x_origin, x_span, x_align, y_origin, y_span, y_align, pad
	input  logic [199:0] s_tdata,
	// func
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// slot, dx, dy, pad
	output logic [71:0]  m_tdata,
	// found
	output logic         m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	logic             req_v_s1;
	func_t            func_s1;
	rec_t             req_s1;
	logic [TOL_W-1:0] tol_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic             found_q;
	logic [2:0]       slot_q;
	logic [31:0]      dx_q, dy_q;

	entry_t    words [ENTRIES];
	logic      match [ENTRIES];
	cell_ctl_t ctl [ENTRIES];

	logic              go, found_d, promote, fill;
	logic [SLOT_W-1:0] first, slot_d, top_idx;
	logic [CNT_W-1:0]  last_pos, promote_pos;
	logic [31:0]       dx_d, dy_d;
	entry_t            load_word, hit_word;
	logic              any_hit;

	assign s_tready  = !req_v_s1;
	assign cfg_ready = 1'b1;
	assign go        = req_v_s1 && (!m_tvalid || m_tready);
	assign last_pos  = count_q - CNT_W'(1);
	assign top_idx   = last_pos[SLOT_W-1:0];

	always_comb begin
		any_hit = 1'b0;
		first   = '0;
		for (int k = ENTRIES - 1; k >= 0; k--) begin
			if (match[k] && (CNT_W'(k) < count_q)) begin
				any_hit = 1'b1;
				first   = SLOT_W'(k);
			end
		end
		hit_word = words[first];
	end

	always_comb begin
		found_d     = 1'b0;
		slot_d      = '0;
		dx_d        = '0;
		dy_d        = '0;
		promote     = 1'b0;
		fill        = 1'b0;
		promote_pos = '0;
		count_d     = count_q;
		load_word   = hit_word;
		unique case (func_s1)
			FN_FIND_EXACT, FN_FIND_SIZE: begin
				if (any_hit) begin
					found_d     = 1'b1;
					slot_d      = hit_word.slot;
					promote     = 1'b1;
					promote_pos = CNT_W'(first);
					if (func_s1 == FN_FIND_SIZE) begin
						dx_d = sat_sub(req_s1.x_origin, hit_word.rec.x_origin);
						dy_d = sat_sub(req_s1.y_origin, hit_word.rec.y_origin);
						load_word.rec.x_origin = req_s1.x_origin;
						load_word.rec.y_origin = req_s1.y_origin;
					end
				end
			end
			FN_ALLOC: begin
				found_d       = 1'b1;
				load_word.rec = req_s1;
				if (count_q < CNT_W'(ENTRIES)) begin
					fill           = 1'b1;
					load_word.slot = count_q[SLOT_W-1:0];
					count_d        = count_q + CNT_W'(1);
				end else begin
					promote        = 1'b1;
					load_word.slot = words[0].slot;
				end
				slot_d = load_word.slot;
			end
			FN_RECENT: begin
				if (count_q != '0) begin
					found_d = 1'b1;
					slot_d  = words[top_idx].slot;
				end
			end
			FN_FLUSH: count_d = '0;
			default: ;
		endcase
	end

	always_comb begin
		for (int k = 0; k < ENTRIES; k++) begin
			ctl[k].exact = (func_s1 == FN_FIND_EXACT);
			ctl[k].sel   = SEL_HOLD;
			if (go) begin
				if (promote && CNT_W'(k) == last_pos) begin
					ctl[k].sel = SEL_LOAD;
				end else if (promote && CNT_W'(k) >= promote_pos && CNT_W'(k) < last_pos) begin
					ctl[k].sel = SEL_SHIFT;
				end else if (fill && CNT_W'(k) == count_q) begin
					ctl[k].sel = SEL_LOAD;
				end
			end
		end
	end

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		lgmt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[k]),
			.req       (req_s1),
			.tol       (tol_q),
			.load_word (load_word),
			.next_word (words[(k + 1 < ENTRIES) ? k + 1 : k]),
			.word      (words[k]),
			.match     (match[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s1 <= 1'b0;
			m_tvalid <= 1'b0;
			count_q  <= '0;
			tol_q    <= TOL_RESET;
		end else begin
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			if (s_tvalid && s_tready) begin
				req_v_s1 <= 1'b1;
			end else if (go) begin
				req_v_s1 <= 1'b0;
			end
			if (go) begin
				m_tvalid <= 1'b1;
				count_q  <= count_d;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= func_t'(s_tuser);
			req_s1  <= '{surface: s_tdata[15:0], transform: s_tdata[31:16],
				x_origin: s_tdata[63:32], x_span: s_tdata[95:64], x_align: s_tdata[112:96],
				y_origin: s_tdata[144:113], y_span: s_tdata[176:145],
				y_align: s_tdata[193:177]};
		end
		if (go) begin
			found_q <= found_d;
			slot_q  <= 3'(slot_d);
			dx_q    <= dx_d;
			dy_q    <= dy_d;
		end
	end

	assign m_tuser = found_q;
	assign m_tdata = {5'd0, dy_q, dx_q, slot_q};

endmodule

[bench/lru_geometry_match_table_top_tb.sv]
// self-checking bench for the layout record table: streamed requests checked against a table model
module lru_geometry_match_table_top_tb;
	import lgmt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0] fn;
		logic [15:0] surf;
		logic [15:0] xf;
		logic [31:0] xo;
		logic [31:0] xs;
		logic [16:0] xa;
		logic [31:0] yo;
		logic [31:0] ys;
		logic [16:0] ya;
	} req_t;

	typedef struct {
		logic found;
		logic [2:0] slot;
		logic [31:0] dx;
		logic [31:0] dy;
	} res_t;

	class table_scoreboard;
		req_t recs[ENTRIES];
		int order[ENTRIES];
		int used;
		logic [15:0] tol;
		res_t pending[$];
		int mismatches;

		function new();
			used = 0;
			tol = TOL_RESET;
			mismatches = 0;
			for (int i = 0; i < ENTRIES; i++) order[i] = 0;
		endfunction

		function bit close(longint a, longint b);
			longint d;
			d = a - b;
			if (d < 0) d = -d;
			return d <= longint'(tol);
		endfunction

		function logic [31:0] clamp(longint v);
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			return v[31:0];
		endfunction

		function void bump(int pos);
			int s;
			s = order[pos];
			for (int k = pos; k + 1 < used; k++) order[k] = order[k + 1];
			order[used - 1] = s;
		endfunction

		function void note_request(req_t r);
			res_t o;
			int s;
			bit hit;
			o = '{1'b0, 3'd0, 32'd0, 32'd0};
			if (r.fn == FN_FIND_EXACT || r.fn == FN_FIND_SIZE) begin
				for (int k = 0; k < used; k++) begin
					s = order[k];
					if (recs[s].surf != r.surf || (r.surf != 0 && recs[s].xf != r.xf)) continue;
					hit = close(longint'($signed(recs[s].xs)), longint'($signed(r.xs)))
						&& close(longint'(recs[s].xa), longint'(r.xa))
						&& close(longint'($signed(recs[s].ys)), longint'($signed(r.ys)))
						&& close(longint'(recs[s].ya), longint'(r.ya));
					if (r.fn == FN_FIND_EXACT)
						hit = hit && close(longint'($signed(recs[s].xo)), longint'($signed(r.xo)))
							&& close(longint'($signed(recs[s].yo)), longint'($signed(r.yo)));
					if (!hit) continue;
					if (r.fn == FN_FIND_SIZE) begin
						o.dx = clamp(longint'($signed(r.xo)) - longint'($signed(recs[s].xo)));
						o.dy = clamp(longint'($signed(r.yo)) - longint'($signed(recs[s].yo)));
						recs[s].xo = r.xo;
						recs[s].yo = r.yo;
					end
					bump(k);
					o.found = 1'b1;
					o.slot = 3'(s);
					break;
				end
			end else if (r.fn == FN_ALLOC) begin
				if (used < ENTRIES) begin
					s = used;
					order[used] = s;
					used++;
				end else begin
					s = order[0];
					bump(0);
				end
				recs[s] = r;
				o.found = 1'b1;
				o.slot = 3'(s);
			end else if (r.fn == FN_RECENT) begin
				if (used > 0) begin
					o.found = 1'b1;
					o.slot = 3'(order[used - 1]);
				end
			end else if (r.fn == FN_FLUSH) begin
				used = 0;
			end
			pending = {pending, o};
		endfunction

		function void check_result(res_t a);
			res_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", a);
				return;
			end
			e = pending.pop_front();
			if (a.found !== e.found || a.slot !== e.slot || a.dx !== e.dx || a.dy !== e.dy) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch expected %p actual %p", e, a);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [199:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [71:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	int send_idle = 0;
	int recv_idle = 0;
	longint cycles = 0;
	table_scoreboard sb;
	req_t pool[$];

	lru_geometry_match_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result('{m_tuser, m_tdata[2:0], m_tdata[34:3], m_tdata[66:35]});
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_word(req_t r);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= r.fn;
		s_tdata <= {6'd0, r.ya, r.ys, r.yo, r.xa, r.xs, r.xo, r.xf, r.surf};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_tol(logic [15:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.tol = v;
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic req_t rand_req();
		req_t r;
		r.fn = 3'($urandom_range(7));
		r.surf = 16'($urandom);
		r.xf = 16'($urandom);
		r.xo = $urandom;
		r.xs = $urandom;
		r.xa = 17'($urandom_range(131071));
		r.yo = $urandom;
		r.ys = $urandom;
		r.ya = 17'($urandom_range(131071));
		return r;
	endfunction

	// mostly lookups near records already stored, so hits and promotions are common
	function automatic req_t near_req(logic [15:0] t);
		req_t r;
		int j;
		if (pool.size() == 0 || $urandom_range(9) == 0) begin
			r = rand_req();
			if ($urandom_range(3) == 0) r.surf = '0;
			if ($urandom_range(1)) r.surf = 16'($urandom_range(3));
			r.xf = 16'($urandom_range(2));
			r.fn = FN_ALLOC;
			pool = {pool, r};
			if (pool.size() > 20) void'(pool.pop_front());
			return r;
		end
		j = $urandom_range(pool.size() - 1);
		r = pool[j];
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5: r.fn = FN_FIND_EXACT;
			6, 7, 8, 9, 10, 11: r.fn = FN_FIND_SIZE;
			12, 13, 14: r.fn = FN_ALLOC;
			15, 16: r.fn = FN_RECENT;
			17: r.fn = FN_FLUSH;
			default: r.fn = 3'(3'd5 + $urandom_range(2));
		endcase
		if ($urandom_range(1)) r.xs = 32'(r.xs + $urandom_range(2 * t) - t);
		if ($urandom_range(2) == 0) r.ya = 17'(r.ya + $urandom_range(1) - 0);
		if (r.fn == FN_FIND_SIZE) begin
			r.xo = $urandom;
			r.yo = $urandom;
		end else if ($urandom_range(1)) begin
			r.xo = 32'(r.xo + $urandom_range(t + 1));
		end
		if ($urandom_range(5) == 0) r.xf = 16'(r.xf + 1);
		if (r.fn == FN_ALLOC) pool = {pool, r};
		if (pool.size() > 20) void'(pool.pop_front());
		return r;
	endfunction

	initial begin
		req_t r;
		logic [15:0] tols[4];
		sb = new();
		tols = '{16'd7, 16'd0, 16'd65535, 16'd300};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, extremes, allocation past full, wraps in saturation
		r = '{FN_RECENT, 16'd0, 16'd0, 32'd0, 32'd0, 17'd0, 32'd0, 32'd0, 17'd0};
		send_word(r);
		r.fn = FN_FIND_EXACT;
		send_word(r);
		r = '{FN_ALLOC, 16'd0, 16'hffff, 32'h8000_0000, 32'h7fff_ffff, 17'd65536,
			32'h7fff_ffff, 32'h8000_0000, 17'd0};
		send_word(r);
		r.xf = 16'd1;
		r.fn = FN_FIND_EXACT;
		send_word(r);
		r.fn = FN_FIND_SIZE;
		r.xo = 32'h7fff_ffff;
		r.yo = 32'h8000_0000;
		send_word(r);
		r = '{FN_ALLOC, 16'hffff, 16'h1234, 32'd5, 32'd10, 17'd1, 32'd6, 32'd11, 17'h1ffff};
		send_word(r);
		r.fn = FN_FIND_EXACT;
		r.xo = 32'd12;
		send_word(r);
		r.xo = 32'd13;
		send_word(r);
		r.xf = 16'h1235;
		send_word(r);
		for (int i = 0; i < 9; i++) begin
			r = rand_req();
			r.fn = FN_ALLOC;
			send_word(r);
		end
		r.fn = FN_RECENT;
		send_word(r);
		r.fn = 3'd7;
		send_word(r);
		r.fn = FN_FLUSH;
		send_word(r);
		r.fn = FN_RECENT;
		send_word(r);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_tol(tols[ph]);
			if (ph == 0) begin
				send_idle = 28;
				recv_idle = 51;
			end else if (ph == 1) begin
				send_idle = 51;
				recv_idle = 28;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int i = 0; i < 260; i++) begin
				if ($urandom_range(9) == 0) send_word(rand_req());
				else send_word(near_req(tols[ph] > 1000 ? 16'd1000 : tols[ph]));
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[filelist.f]
design/lgmt_pkg.sv
design/lgmt_cell.sv
design/lru_geometry_match_table_top.sv
bench/lru_geometry_match_table_top_tb.sv
